// ===== src/ptrs_pkg.sv =====
// Shared types and codes for the periodic task release scheduler.
// Depends on nothing; used by periodic_task_release_scheduler.
`default_nettype none
package ptrs_pkg;

    localparam int MAX_TASKS_DEF = 8;

    typedef enum logic [1:0] {
        ACT_CREATE   = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_DISPATCH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_FULL       = 2'd1,
        RES_NOT_FOUND  = 2'd2,
        RES_NONE_READY = 2'd3
    } t_result;

    typedef enum logic [1:0] {
        TS_WAITING = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_DELETED = 2'd3
    } t_tstat;

    typedef struct packed {
        logic [15:0] handle;
        logic [2:0]  prio;
        logic [15:0] period;
        t_tstat      tstat;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_DIV,
        ST_DWB
    } t_state;

endpackage
`default_nettype wire

// ===== src/periodic_task_release_scheduler.sv =====
// Periodic task release scheduler: task table in a one-port-read memory, walked per transaction.
// Depends on ptrs_pkg.
// Create: result registered from the request. Delete/dispatch: each slot walked passes ST_RD and
// ST_EVAL (up to MAX_TASKS slots). Tick: a live slot with nonzero period also passes the shared
// 16-step remainder unit and ST_DWB. One transaction at a time; a result may wait in the output
// register, and the next transaction is taken once it has been delivered. Reset (synchronous,
// active low) clears count, scan position, tick counter (to 1) and priority limit (to 5); table
// memory is not cleared, and slots at or above the count are never used.
`default_nettype none
module periodic_task_release_scheduler #(
    parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [15:0] i_task_handle,
    input  wire  [2:0]  i_priority_req,
    input  wire  [15:0] i_period,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_task_handle_out,
    output logic [2:0]  o_task_slot
);
    import ptrs_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_TASKS);

    // task table memory
    t_entry        mem [MAX_TASKS];
    t_entry        r_rd_data;
    logic          w_en;
    logic [SW-1:0] w_addr;
    t_entry        w_data;

    // control and data registers
    t_state        r_state, n_state;
    t_action       r_act, n_act;
    logic [15:0]   r_hdl, n_hdl;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_tick, n_tick;
    logic [SW-1:0] r_scan, n_scan;
    logic [SW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic          r_found, n_found;
    logic [2:0]    r_lowp;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_dvd, n_dvd;
    logic [3:0]    r_dcnt, n_dcnt;
    logic          r_out_valid, n_out_valid;
    t_result       r_ostat, n_ostat;
    logic [15:0]   r_ohdl, n_ohdl;
    logic [2:0]    r_oslot, n_oslot;

    logic          in_acc;
    logic          idx_last;
    logic          k_last;
    logic [SW-1:0] idx_wrap;
    logic [16:0]   trial;
    logic [16:0]   trial_sub;

    assign o_in_stall        = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc            = i_in_valid && !o_in_stall;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_ostat;
    assign o_task_handle_out = r_ohdl;
    assign o_task_slot       = r_oslot;

    assign idx_last  = ((CW'(r_idx) + CW'(1)) == r_count);
    assign k_last    = (r_k == CW'(MAX_TASKS - 1));
    assign idx_wrap  = (r_idx == LAST_SLOT) ? '0 : r_idx + SW'(1);
    assign trial     = {r_rem, r_dvd[15]};
    assign trial_sub = trial - {1'b0, r_rd_data.period};

    // memory: one write, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_data <= mem[r_idx];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowp <= 3'd5;
        end else if (i_cfg_wr_en) begin
            r_lowp <= i_cfg_wr_data;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_tick      <= 16'd1;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tick      <= n_tick;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_hdl   <= n_hdl;
        r_idx   <= n_idx;
        r_k     <= n_k;
        r_found <= n_found;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_dcnt  <= n_dcnt;
        r_ostat <= n_ostat;
        r_ohdl  <= n_ohdl;
        r_oslot <= n_oslot;
    end

    // sequencer: next state, memory writes, results
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_hdl       = r_hdl;
        n_count     = r_count;
        n_tick      = r_tick;
        n_scan      = r_scan;
        n_idx       = r_idx;
        n_k         = r_k;
        n_found     = r_found;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_ostat     = r_ostat;
        n_ohdl      = r_ohdl;
        n_oslot     = r_oslot;
        w_en        = 1'b0;
        w_addr      = r_idx;
        w_data      = r_rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_act   = t_action'(i_action);
                    n_hdl   = i_task_handle;
                    n_found = 1'b0;
                    n_k     = '0;
                    n_ohdl  = '0;
                    n_oslot = '0;
                    unique case (t_action'(i_action))
                        ACT_CREATE: begin
                            n_out_valid = 1'b1;
                            if (r_count < MAX_CNT) begin
                                w_en          = 1'b1;
                                w_addr        = SW'(r_count);
                                w_data.handle = i_task_handle;
                                w_data.prio   = i_priority_req;
                                w_data.period = i_period;
                                w_data.tstat  = TS_WAITING;
                                n_count       = r_count + CW'(1);
                                n_ostat       = RES_OK;
                                n_oslot       = 3'(r_count);
                            end else begin
                                n_ostat = RES_FULL;
                            end
                        end
                        ACT_DELETE, ACT_TICK: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                if (t_action'(i_action) == ACT_TICK) begin
                                    n_ostat = RES_OK;
                                    n_tick  = r_tick + 16'd1;
                                end else begin
                                    n_ostat = RES_NOT_FOUND;
                                end
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                            n_idx   = r_scan;
                            n_state = ST_RD;
                        end
                    endcase
                end
            end

            ST_RD: begin
                n_state = ST_EVAL;
            end

            ST_EVAL: begin
                n_state = ST_RD;
                unique case (r_act)
                    ACT_DELETE: begin
                        if (r_hdl != 16'd0 && r_rd_data.tstat != TS_DELETED &&
                            r_rd_data.handle == r_hdl) begin
                            w_en          = 1'b1;
                            w_data.handle = '0;
                            w_data.prio   = '0;
                            w_data.period = '0;
                            w_data.tstat  = TS_DELETED;
                            n_found       = 1'b1;
                        end
                        n_idx = r_idx + SW'(1);
                        if (idx_last) begin
                            n_state     = ST_IDLE;
                            n_out_valid = 1'b1;
                            n_ostat     = (n_found) ? RES_OK : RES_NOT_FOUND;
                        end
                    end
                    ACT_TICK: begin
                        if (r_rd_data.tstat == TS_DELETED || r_rd_data.period == 16'd0) begin
                            if (r_rd_data.tstat != TS_DELETED) begin
                                w_en         = 1'b1;
                                w_data.tstat = TS_WAITING;
                            end
                            n_idx = r_idx + SW'(1);
                            if (idx_last) begin
                                n_state     = ST_IDLE;
                                n_out_valid = 1'b1;
                                n_ostat     = RES_OK;
                                n_tick      = r_tick + 16'd1;
                            end
                        end else begin
                            n_rem   = '0;
                            n_dvd   = r_tick;
                            n_dcnt  = '0;
                            n_state = ST_DIV;
                        end
                    end
                    default: begin
                        if (CW'(r_idx) < r_count && r_rd_data.tstat == TS_READY &&
                            r_rd_data.prio <= r_lowp) begin
                            w_en         = 1'b1;
                            w_data.tstat = TS_WAITING;
                            n_scan       = idx_wrap;
                            n_state      = ST_IDLE;
                            n_out_valid  = 1'b1;
                            n_ostat      = RES_OK;
                            n_ohdl       = r_rd_data.handle;
                            n_oslot      = 3'(r_idx);
                        end else begin
                            n_idx = idx_wrap;
                            n_k   = r_k + CW'(1);
                            if (k_last) begin
                                n_state     = ST_IDLE;
                                n_out_valid = 1'b1;
                                n_ostat     = RES_NONE_READY;
                            end
                        end
                    end
                endcase
            end

            // one remainder bit per cycle: tick mod period
            ST_DIV: begin
                n_dvd  = {r_dvd[14:0], 1'b0};
                n_rem  = trial_sub[16] ? trial[15:0] : trial_sub[15:0];
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    n_state = ST_DWB;
                end
            end

            ST_DWB: begin
                w_en         = 1'b1;
                w_data.tstat = (r_rem == 16'd0) ? TS_READY : TS_WAITING;
                n_idx        = r_idx + SW'(1);
                n_state      = ST_RD;
                if (idx_last) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_ostat     = RES_OK;
                    n_tick      = r_tick + 16'd1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT) else $error("task count beyond table size");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= LAST_SLOT) else $error("scan position beyond table");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall) else $error("input taken while busy");
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_DIV) |=> $stable(r_tick))
        else $error("tick counter moved mid-walk");

endmodule
`default_nettype wire
